>>> rtl/dhw_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types, microcode program and arithmetic helpers of the smoother.
package dhw_pkg;

   localparam int SEASON_DEPTH = 24;
   localparam int COUNT_WIDTH = 24;
   localparam int SLOT_W = $clog2(SEASON_DEPTH);
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 33;
   localparam int PROD_W = 64;
   localparam logic [15:0] GAIN_ONE = 16'd32768;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_START  = 2'd1,
      OP_SAMPLE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      CSR_LEVEL_GAIN    = 3'd0,
      CSR_TREND_GAIN    = 3'd1,
      CSR_SEASON_GAIN   = 3'd2,
      CSR_DAMPING       = 3'd3,
      CSR_SEASON_LENGTH = 3'd4,
      CSR_START_LEVEL   = 3'd5,
      CSR_START_TREND   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        level_gain;
      logic [15:0]        trend_gain;
      logic [15:0]        season_gain;
      logic [15:0]        damping;
      logic [4:0]         season_length;
      logic signed [31:0] start_level;
      logic signed [31:0] start_trend;
   } cfg_type;

   typedef enum logic [1:0] {
      MA_TREND,
      MA_ERR,
      MA_ACC
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_PHI,
      MB_ERR,
      MB_ALPHA,
      MB_BETA,
      MB_GAMMA
   } mul_b_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_PT,
      ACT_BASE,
      ACT_FC_D1,
      ACT_ERR,
      ACT_NL,
      ACT_SUM_D2,
      ACT_D3,
      ACT_TR,
      ACT_SEAS
   } act_type;

   typedef logic [3:0] step_type;

   typedef struct packed {
      mul_a_type mul_a;
      mul_b_type mul_b;
      logic      mul_en;
      act_type   act;
      logic      jump_halted;
      step_type  target;
      logic      done;
   } uword_type;

   typedef struct packed {
      logic      fire;
      uword_type uw;
   } ctrl_type;

   typedef struct packed {
      logic signed [31:0]     forecast;
      logic signed [31:0]     error;
      logic [63:0]            sum;
      logic [COUNT_WIDTH-1:0] count;
      logic                   overflow;
   } result_type;

   localparam step_type STEP_EXIT = 4'd10;

   function automatic uword_type ucode(input step_type step);
      uword_type w;
      w = '{MA_TREND, MB_PHI, 1'b0, ACT_NONE, 1'b0, 4'd0, 1'b0};
      case (step)
         4'd0: w = '{MA_TREND, MB_PHI, 1'b1, ACT_NONE, 1'b0, 4'd0, 1'b0};
         4'd1: w = '{MA_TREND, MB_PHI, 1'b0, ACT_PT, 1'b0, 4'd0, 1'b0};
         4'd2: w = '{MA_TREND, MB_PHI, 1'b0, ACT_BASE, 1'b0, 4'd0, 1'b0};
         4'd3: w = '{MA_TREND, MB_PHI, 1'b0, ACT_FC_D1, 1'b0, 4'd0, 1'b0};
         4'd4: w = '{MA_ACC, MB_ALPHA, 1'b1, ACT_ERR, 1'b0, 4'd0, 1'b0};
         4'd5: w = '{MA_ERR, MB_ERR, 1'b1, ACT_NL, 1'b1, STEP_EXIT, 1'b0};
         4'd6: w = '{MA_TREND, MB_PHI, 1'b0, ACT_SUM_D2, 1'b0, 4'd0, 1'b0};
         4'd7: w = '{MA_ACC, MB_BETA, 1'b1, ACT_D3, 1'b0, 4'd0, 1'b0};
         4'd8: w = '{MA_ACC, MB_GAMMA, 1'b1, ACT_TR, 1'b0, 4'd0, 1'b0};
         4'd9: w = '{MA_TREND, MB_PHI, 1'b0, ACT_SEAS, 1'b0, 4'd0, 1'b1};
         default: w = '{MA_TREND, MB_PHI, 1'b0, ACT_NONE, 1'b0, 4'd0, 1'b1};
      endcase
      return w;
   endfunction

   function automatic logic signed [MUL_A_W-1:0] ext(input logic signed [31:0] v);
      return MUL_A_W'(v);
   endfunction

   function automatic logic signed [MUL_A_W-1:0] mq(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      r = p + PROD_W'(16384);
      return r[15 +: MUL_A_W];
   endfunction

   function automatic logic out32(input logic signed [MUL_A_W-1:0] v);
      return !((&v[MUL_A_W-1:31]) || !(|v[MUL_A_W-1:31]));
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [MUL_A_W-1:0] v);
      logic signed [31:0] r;
      if (out32(v)) begin
         r = v[MUL_A_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [MUL_B_W-1:0] gain_op(input logic [15:0] g);
      return MUL_B_W'((g > GAIN_ONE) ? GAIN_ONE : g);
   endfunction

endpackage

>>> rtl/dhw_if.sv
`timescale 1ns / 1ps
// Channel interfaces for requests, results and register writes.
interface dhw_req_if import dhw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [31:0] sample;
   logic [4:0]         season_slot;
   logic signed [31:0] season_value;

   modport source(output valid, op, sample, season_slot, season_value, input ready);
   modport sink(input valid, op, sample, season_slot, season_value, output ready);
endinterface

interface dhw_rsp_if import dhw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     forecast;
   logic signed [31:0]     error;
   logic [63:0]            squared_error_sum;
   logic [COUNT_WIDTH-1:0] point_count;
   logic                   overflow;

   modport source(output valid, forecast, error, squared_error_sum, point_count, overflow,
                  input ready);
   modport sink(input valid, forecast, error, squared_error_sum, point_count, overflow,
                output ready);
endinterface

interface dhw_csr_if import dhw_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/dhw_useq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program ROM lookup and conditional jump.
module dhw_useq import dhw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     launch,
   input  logic     hold,
   input  logic     halted,
   output logic     busy,
   output ctrl_type ctrl
);

   logic      busy_ff, busy_in;
   step_type  step_ff, step_in;
   uword_type uw;
   logic      fire;

   assign uw   = ucode(step_ff);
   assign fire = busy_ff && !(uw.done && hold);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (launch) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (fire) begin
         if (uw.done) begin
            busy_in = 1'b0;
         end else if (uw.jump_halted && halted) begin
            step_in = uw.target;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy      = busy_ff;
   assign ctrl.fire = fire;
   assign ctrl.uw   = uw;

endmodule

>>> rtl/dhw_datapath.sv
`timescale 1ns / 1ps
// Datapath: state registers, seasonal memory, shared multiplier and adders.
module dhw_datapath import dhw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_fire,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_sample,
   input  logic [4:0]         req_slot,
   input  logic signed [31:0] req_value,
   input  ctrl_type           ctrl,
   output logic               halted,
   output result_type         result
);

   logic signed [31:0]     level_ff, trend_ff;
   logic [SLOT_W-1:0]      pos_ff;
   logic [63:0]            sum_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   halted_ff;

   logic signed [31:0]        x_ff, s_ff, pt_ff, fc_ff, err_ff, nl_ff;
   logic signed [32:0]        base_ff;
   logic signed [MUL_A_W-1:0] acc_ff;
   logic                      ovf_ff;
   logic signed [PROD_W-1:0]  prod_ff;

   logic [31:0] season_mem [SEASON_DEPTH];
   logic [31:0] rdata_ff;

   logic signed [MUL_A_W-1:0]         a_c;
   logic signed [MUL_B_W-1:0]         b_c;
   logic signed [MUL_A_W+MUL_B_W-1:0] prod_full;
   logic signed [MUL_A_W-1:0]         mq_c, nl_raw;
   logic [PROD_W-1:0]                 rnd_c;
   logic [64:0]                       sum_c;
   logic [SLOT_W:0]                   len_c, pos_inc;
   logic                              act_en, load_en, wen;
   logic [SLOT_W-1:0]                 waddr;
   logic [31:0]                       wdata;

   always_comb begin
      case (ctrl.uw.mul_a)
         MA_TREND: a_c = ext(trend_ff);
         MA_ERR:   a_c = ext(err_ff);
         MA_ACC:   a_c = acc_ff;
         default:  a_c = acc_ff;
      endcase
      case (ctrl.uw.mul_b)
         MB_PHI:   b_c = gain_op(cfg.damping);
         MB_ERR:   b_c = MUL_B_W'(err_ff);
         MB_ALPHA: b_c = gain_op(cfg.level_gain);
         MB_BETA:  b_c = gain_op(cfg.trend_gain);
         MB_GAMMA: b_c = gain_op(cfg.season_gain);
         default:  b_c = gain_op(cfg.damping);
      endcase
   end

   assign prod_full = a_c * b_c;
   assign mq_c      = mq(prod_ff);
   assign nl_raw    = MUL_A_W'(base_ff) + mq_c;
   assign rnd_c     = $unsigned(prod_ff) + PROD_W'(32768);
   assign sum_c     = {1'b0, sum_ff} + {17'b0, rnd_c[PROD_W-1:16]};

   always_comb begin
      if (cfg.season_length < 5'd2) begin
         len_c = (SLOT_W+1)'(2);
      end else if (32'(cfg.season_length) > SEASON_DEPTH) begin
         len_c = (SLOT_W+1)'(SEASON_DEPTH);
      end else begin
         len_c = (SLOT_W+1)'(cfg.season_length);
      end
   end

   assign pos_inc = {1'b0, pos_ff} + (SLOT_W+1)'(1);
   assign act_en  = ctrl.fire;
   assign load_en = req_fire && (req_op == OP_LOAD) && (32'(req_slot) < SEASON_DEPTH);
   assign wen     = load_en || (act_en && (ctrl.uw.act == ACT_SEAS));
   assign waddr   = load_en ? SLOT_W'(req_slot) : pos_ff;
   assign wdata   = load_en ? req_value : sat32(ext(s_ff) + mq_c);

   always_ff @(posedge clock) begin
      if (wen) begin
         season_mem[waddr] <= wdata;
      end
      rdata_ff <= season_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         trend_ff  <= '0;
         pos_ff    <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            x_ff <= req_sample;
            if (req_op == OP_START) begin
               level_ff  <= cfg.start_level;
               trend_ff  <= cfg.start_trend;
               pos_ff    <= '0;
               sum_ff    <= '0;
               count_ff  <= '0;
               halted_ff <= 1'b0;
            end
         end
         if (act_en && ctrl.uw.mul_en) begin
            prod_ff <= prod_full[PROD_W-1:0];
         end
         if (act_en) begin
            unique case (ctrl.uw.act)
               ACT_NONE: begin
               end
               ACT_PT: begin
                  pt_ff <= mq_c[31:0];
                  s_ff  <= rdata_ff;
               end
               ACT_BASE: begin
                  base_ff <= 33'(level_ff) + 33'(pt_ff);
               end
               ACT_FC_D1: begin
                  fc_ff  <= sat32(MUL_A_W'(base_ff) + ext(s_ff));
                  acc_ff <= ext(x_ff) - ext(s_ff) - MUL_A_W'(base_ff);
               end
               ACT_ERR: begin
                  err_ff <= sat32(ext(x_ff) - ext(fc_ff));
               end
               ACT_NL: begin
                  nl_ff  <= sat32(nl_raw);
                  ovf_ff <= out32(nl_raw);
               end
               ACT_SUM_D2: begin
                  sum_ff <= sum_c[64] ? '1 : sum_c[63:0];
                  if (!(&count_ff)) begin
                     count_ff <= count_ff + COUNT_WIDTH'(1);
                  end
                  acc_ff <= ext(nl_ff) - ext(level_ff) - ext(pt_ff);
               end
               ACT_D3: begin
                  acc_ff <= ext(x_ff) - ext(nl_ff) - ext(s_ff);
               end
               ACT_TR: begin
                  trend_ff <= sat32(ext(pt_ff) + mq_c);
                  level_ff <= nl_ff;
                  if (ovf_ff) begin
                     halted_ff <= 1'b1;
                  end
               end
               ACT_SEAS: begin
                  pos_ff <= (pos_inc >= len_c) ? '0 : pos_inc[SLOT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign halted          = halted_ff;
   assign result.forecast = fc_ff;
   assign result.error    = err_ff;
   assign result.sum      = sum_ff;
   assign result.count    = count_ff;
   assign result.overflow = halted_ff;

endmodule

>>> rtl/damped_holt_winters_update_top.sv
`timescale 1ns / 1ps
// Top level of the damped-trend additive Holt-Winters update block.
// A sample request runs the full microcode program from transfer to result, or exits after the new
// level when the run is halted; the request channel stays busy until the result is registered.
// The pace is set by the microcode program, which funnels five products through one multiplier.
// Load, start and unused requests leave the request channel free and give no result.
// Synchronous reset restores the register defaults and clears level, trend, position,
// sum, count and the halted flag; seasonal entries keep no reset value.
module damped_holt_winters_update_top import dhw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dhw_req_if.sink   req_ch,
   dhw_rsp_if.source rsp_ch,
   dhw_csr_if.sink   csr_ch
);

   cfg_type    cfg_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   ctrl_type   ctrl;
   logic       busy, halted, req_fire, launch, hold;

   assign req_ch.ready = !busy;
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && !busy;
   assign launch       = req_fire && (req_ch.op == OP_SAMPLE);
   assign hold         = rsp_valid_ff && !rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_gain    <= 16'd6554;
         cfg_ff.trend_gain    <= 16'd6554;
         cfg_ff.season_gain   <= 16'd6554;
         cfg_ff.damping       <= 16'd31130;
         cfg_ff.season_length <= 5'd12;
         cfg_ff.start_level   <= '0;
         cfg_ff.start_trend   <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_LEVEL_GAIN:    cfg_ff.level_gain    <= csr_ch.data[15:0];
            CSR_TREND_GAIN:    cfg_ff.trend_gain    <= csr_ch.data[15:0];
            CSR_SEASON_GAIN:   cfg_ff.season_gain   <= csr_ch.data[15:0];
            CSR_DAMPING:       cfg_ff.damping       <= csr_ch.data[15:0];
            CSR_SEASON_LENGTH: cfg_ff.season_length <= csr_ch.data[4:0];
            CSR_START_LEVEL:   cfg_ff.start_level   <= csr_ch.data;
            CSR_START_TREND:   cfg_ff.start_trend   <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   dhw_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .launch (launch),
      .hold   (hold),
      .halted (halted),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   dhw_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_fire   (req_fire),
      .req_op     (req_ch.op),
      .req_sample (req_ch.sample),
      .req_slot   (req_ch.season_slot),
      .req_value  (req_ch.season_value),
      .ctrl       (ctrl),
      .halted     (halted),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.fire && ctrl.uw.done) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= result;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.forecast          = rsp_ff.forecast;
   assign rsp_ch.error             = rsp_ff.error;
   assign rsp_ch.squared_error_sum = rsp_ff.sum;
   assign rsp_ch.point_count       = rsp_ff.count;
   assign rsp_ch.overflow          = rsp_ff.overflow;

endmodule

>>> rtl/dhw_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the smoother top level and the bind that attaches it.
module dhw_checker import dhw_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [1:0]             req_op,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic signed [31:0]     rsp_forecast,
   input logic [63:0]            rsp_sum,
   input logic [COUNT_WIDTH-1:0] rsp_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_forecast) && $stable(rsp_sum)
                                  && $stable(rsp_count))
      else $error("Result changed while stalled.");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_SAMPLE |=> !req_ready)
      else $error("Request taken while a sample is in progress.");

   a_other_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op != OP_SAMPLE |=> req_ready)
      else $error("Load or start transfer blocked the request channel.");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_SAMPLE |=> !$rose(rsp_valid))
      else $error("Result appeared right after a sample transfer.");

endmodule

bind damped_holt_winters_update_top dhw_checker u_dhw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_op       (req_ch.op),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_forecast (rsp_ch.forecast),
   .rsp_sum      (rsp_ch.squared_error_sum),
   .rsp_count    (rsp_ch.point_count)
);

>>> tb/dhw_forecast_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the smoother's results from observed transfers and compares them.
module dhw_forecast_checker import dhw_pkg::*; (
   input  logic clock,
   input  logic reset,
   dhw_req_if   req_ch,
   dhw_rsp_if   rsp_ch,
   dhw_csr_if   csr_ch,
   output int   failures,
   output int   outstanding
);

   localparam int REPORT_LIMIT = 10;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint S32_MIN = -64'sh0000_0000_8000_0000;

   cfg_type                cfg;
   longint                 level_q;
   longint                 trend_q;
   longint                 season_q [SEASON_DEPTH];
   int                     position_q;
   logic [63:0]            sum_q;
   logic [COUNT_WIDTH-1:0] count_q;
   logic                   halted_q;
   result_type             forecast_q [$];
   int                     fail_n;

   function automatic longint clip32(input longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   function automatic longint gain_mul(input longint v, input logic [15:0] g);
      longint gv;
      gv = (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
      return (v * gv + 64'sd16384) >>> 15;
   endfunction

   task automatic holt_winters_step(input longint x, output result_type r);
      int          len;
      int          idx;
      longint      s;
      longint      pt;
      longint      base;
      longint      fc;
      longint      err;
      longint      raw;
      longint      nl;
      logic [63:0] sq;
      len = int'(cfg.season_length);
      if (len < 2) len = 2;
      if (len > SEASON_DEPTH) len = SEASON_DEPTH;
      idx = (position_q < SEASON_DEPTH) ? position_q : 0;
      s = season_q[idx];
      pt = gain_mul(trend_q, cfg.damping);
      base = level_q + pt;
      fc = clip32(base + s);
      err = clip32(x - fc);
      if (!halted_q) begin
         sq = (64'(err * err) + 64'd32768) >> 16;
         sum_q = (sum_q > ~64'd0 - sq) ? ~64'd0 : sum_q + sq;
         if (count_q != COUNT_MAX) count_q = count_q + 1'b1;
         raw = base + gain_mul(x - s - base, cfg.level_gain);
         nl = clip32(raw);
         trend_q = clip32(pt + gain_mul(nl - level_q - pt, cfg.trend_gain));
         season_q[idx] = clip32(s + gain_mul(x - nl - s, cfg.season_gain));
         level_q = nl;
         position_q = (idx + 1 >= len) ? 0 : idx + 1;
         if (raw != nl) halted_q = 1'b1;
      end
      r.forecast = fc[31:0];
      r.error = err[31:0];
      r.sum = sum_q;
      r.count = count_q;
      r.overflow = halted_q;
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      result_type pred;
      if (reset) begin
         cfg.level_gain = 16'd6554;
         cfg.trend_gain = 16'd6554;
         cfg.season_gain = 16'd6554;
         cfg.damping = 16'd31130;
         cfg.season_length = 5'd12;
         cfg.start_level = '0;
         cfg.start_trend = '0;
         level_q = 0;
         trend_q = 0;
         foreach (season_q[i]) season_q[i] = 0;
         position_q = 0;
         sum_q = '0;
         count_q = '0;
         halted_q = 1'b0;
         forecast_q.delete();
         fail_n = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_LEVEL_GAIN:    cfg.level_gain = csr_ch.data[15:0];
               CSR_TREND_GAIN:    cfg.trend_gain = csr_ch.data[15:0];
               CSR_SEASON_GAIN:   cfg.season_gain = csr_ch.data[15:0];
               CSR_DAMPING:       cfg.damping = csr_ch.data[15:0];
               CSR_SEASON_LENGTH: cfg.season_length = csr_ch.data[4:0];
               CSR_START_LEVEL:   cfg.start_level = csr_ch.data;
               CSR_START_TREND:   cfg.start_trend = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.op)
               OP_LOAD: begin
                  if (req_ch.season_slot < SEASON_DEPTH)
                     season_q[req_ch.season_slot] = longint'(req_ch.season_value);
               end
               OP_START: begin
                  level_q = longint'($signed(cfg.start_level));
                  trend_q = longint'($signed(cfg.start_trend));
                  position_q = 0;
                  sum_q = '0;
                  count_q = '0;
                  halted_q = 1'b0;
               end
               OP_SAMPLE: begin
                  holt_winters_step(longint'(req_ch.sample), pred);
                  forecast_q.push_back(pred);
               end
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.forecast = rsp_ch.forecast;
            got.error = rsp_ch.error;
            got.sum = rsp_ch.squared_error_sum;
            got.count = rsp_ch.point_count;
            got.overflow = rsp_ch.overflow;
            if (forecast_q.size() == 0) begin
               if (fail_n < REPORT_LIMIT)
                  $display("%0t: result transfer with no sample outstanding: fc=%0d err=%0d",
                           $realtime, $signed(got.forecast), $signed(got.error));
               fail_n++;
            end else begin
               want = forecast_q.pop_front();
               if (got !== want) begin
                  if (fail_n < REPORT_LIMIT) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected fc=%0d err=%0d sum=%0d count=%0d ovf=%0b",
                              $signed(want.forecast), $signed(want.error), want.sum,
                              want.count, want.overflow);
                     $display("   actual   fc=%0d err=%0d sum=%0d count=%0d ovf=%0b",
                              $signed(got.forecast), $signed(got.error), got.sum,
                              got.count, got.overflow);
                  end
                  fail_n++;
               end
            end
         end
      end
      failures <= fail_n;
      outstanding <= forecast_q.size();
   end

endmodule

>>> tb/tb_damped_holt_winters_update_top.sv
`timescale 1ns / 1ps
// Testbench top that drives stimulus into the smoother and reports the verdict.
module tb_damped_holt_winters_update_top;
   import dhw_pkg::*;

   localparam int ITEM_TARGET = 700;
   localparam int CALM_TAIL = 120;
   localparam int DRAIN_CYCLES = 12;
   localparam int STALL_LIMIT = 2000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   items_sent;
   int   walk;

   dhw_req_if req_bus ();
   dhw_rsp_if rsp_bus ();
   dhw_csr_if csr_bus ();

   damped_holt_winters_update_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   dhw_forecast_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_ch      (csr_bus),
      .failures    (fail_count),
      .outstanding (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] q16_value(input int spread);
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom();
         default: return 32'(int'($urandom_range(0, 2 * spread)) - spread);
      endcase
   endfunction

   function automatic logic [15:0] gain_value();
      case ($urandom_range(0, 11))
         0: return 16'd0;
         1: return GAIN_ONE;
         2: return 16'($urandom_range(32769, 65535));
         3: return 16'hFFFF;
         4: return 16'd1;
         default: return 16'($urandom_range(500, 30000));
      endcase
   endfunction

   task automatic send_req(input logic [1:0] op, input logic [31:0] sample,
                           input logic [4:0] slot, input logic [31:0] value);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.sample <= sample;
      req_bus.season_slot <= slot;
      req_bus.season_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      if (op == OP_SAMPLE || op == OP_START || (op == OP_LOAD && slot < SEASON_DEPTH))
         items_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin : watchdog
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            stall = 0;
         else
            stall++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int          n;
      int          pick;
      logic [31:0] v;
      req_bus.valid <= 1'b0;
      req_bus.op <= OP_LOAD;
      req_bus.sample <= '0;
      req_bus.season_slot <= '0;
      req_bus.season_value <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_LEVEL_GAIN;
      csr_bus.data <= '0;
      reset <= 1'b1;
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      items_sent = 0;
      walk = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Every seasonal entry is written before the first sample reads one.
      for (int i = 0; i < SEASON_DEPTH; i++) begin
         if (i == 0) v = 32'h7FFF_FFFF;
         else if (i == 1) v = 32'h8000_0000;
         else v = 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
         send_req(OP_LOAD, $urandom(), 5'(i), v);
      end
      send_req(OP_LOAD, $urandom(), 5'd24, $urandom());
      send_req(OP_LOAD, $urandom(), 5'd31, $urandom());
      send_req(OP_UNUSED, $urandom(), 5'($urandom()), $urandom());
      send_req(OP_START, $urandom(), 5'($urandom()), $urandom());
      send_req(OP_SAMPLE, 32'h8000_0000, 5'd0, 32'd0);
      send_req(OP_SAMPLE, 32'h7FFF_FFFF, 5'd0, 32'd0);
      send_req(OP_SAMPLE, 32'd0, 5'd0, 32'd0);
      send_req(OP_SAMPLE, 32'h0003_8000, 5'd0, 32'd0);
      settle();

      // Full level gain drives the level past the range and halts the run.
      write_reg(CSR_LEVEL_GAIN, 32'd32768);
      write_reg(CSR_TREND_GAIN, 32'd0);
      write_reg(CSR_SEASON_GAIN, 32'h0000_FFFF);
      write_reg(CSR_DAMPING, 32'd0);
      write_reg(CSR_SEASON_LENGTH, 32'd0);
      write_reg(CSR_START_LEVEL, 32'h7FFF_FFFF);
      write_reg(CSR_START_TREND, 32'h8000_0000);
      csr_bus.valid <= 1'b0;
      send_req(OP_LOAD, 32'd0, 5'd0, 32'h8000_0000);
      send_req(OP_START, 32'd0, 5'd0, 32'd0);
      send_req(OP_SAMPLE, 32'h7FFF_FFFF, 5'd0, 32'd0);
      send_req(OP_SAMPLE, 32'h0000_3039, 5'd0, 32'd0);
      send_req(OP_SAMPLE, 32'hFFFF_FFFF, 5'd0, 32'd0);
      send_req(OP_START, 32'd0, 5'd0, 32'd0);
      send_req(OP_SAMPLE, 32'd0, 5'd0, 32'd0);
      settle();

      write_reg(CSR_LEVEL_GAIN, 32'd0);
      write_reg(CSR_TREND_GAIN, 32'd32768);
      write_reg(CSR_DAMPING, 32'hFFFF_FFFF);
      write_reg(CSR_SEASON_LENGTH, 32'd31);
      write_reg(CSR_START_LEVEL, 32'd0);
      write_reg(CSR_START_TREND, 32'h0001_0000);
      csr_bus.valid <= 1'b0;
      send_req(OP_START, 32'd0, 5'd0, 32'd0);
      repeat (4) send_req(OP_SAMPLE, 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19)),
                          5'd0, 32'd0);

      while (items_sent < ITEM_TARGET) begin
         settle();
         if (items_sent >= ITEM_TARGET - CALM_TAIL) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: req_idle_pct = 0;
               1: req_idle_pct = 15;
               default: req_idle_pct = 45;
            endcase
            case ($urandom_range(0, 2))
               0: rsp_idle_pct = 0;
               1: rsp_idle_pct = 15;
               default: rsp_idle_pct = 45;
            endcase
         end
         if ($urandom_range(0, 2) != 0) write_reg(CSR_LEVEL_GAIN, {16'($urandom()), gain_value()});
         if ($urandom_range(0, 2) != 0) write_reg(CSR_TREND_GAIN, {16'($urandom()), gain_value()});
         if ($urandom_range(0, 2) != 0)
            write_reg(CSR_SEASON_GAIN, {16'($urandom()), gain_value()});
         if ($urandom_range(0, 2) != 0) begin
            v = {16'($urandom()), ($urandom_range(0, 1) != 0) ? gain_value() :
                 16'($urandom_range(26000, 32768))};
            write_reg(CSR_DAMPING, v);
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0: v[4:0] = 5'($urandom_range(0, 1));
               1: v[4:0] = 5'($urandom_range(25, 31));
               2: v[4:0] = 5'd24;
               3: v[4:0] = 5'd2;
               4, 5: v[4:0] = 5'($urandom_range(9, 23));
               default: v[4:0] = 5'($urandom_range(3, 8));
            endcase
            v[31:5] = 27'($urandom());
            write_reg(CSR_SEASON_LENGTH, v);
         end
         if ($urandom_range(0, 2) != 0) write_reg(CSR_START_LEVEL, q16_value(1 << 22));
         if ($urandom_range(0, 2) != 0) write_reg(CSR_START_TREND, q16_value(1 << 16));
         csr_bus.valid <= 1'b0;
         walk = int'($urandom_range(0, 1 << 23)) - (1 << 22);
         send_req(OP_START, $urandom(), 5'($urandom()), $urandom());
         n = $urandom_range(40, 80);
         repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
               walk = walk + int'($urandom_range(0, 1 << 17)) - (1 << 16);
               if (walk > (1 << 26) || walk < -(1 << 26)) walk = 0;
               if ($urandom_range(0, 3) != 0)
                  v = 32'(walk + (int'(items_sent % 6) - 3) * 65536);
               else
                  v = q16_value(1 << 20);
               send_req(OP_SAMPLE, v, 5'($urandom()), $urandom());
            end else if (pick < 80) begin
               send_req(OP_LOAD, $urandom(), 5'($urandom_range(0, 31)), q16_value(1 << 18));
            end else if (pick < 86) begin
               send_req(OP_START, $urandom(), 5'($urandom()), $urandom());
            end else if (pick < 90) begin
               send_req(OP_UNUSED, $urandom(), 5'($urandom()), $urandom());
            end else begin
               send_req(OP_SAMPLE, $urandom(), 5'($urandom()), $urandom());
            end
         end
      end

      settle();
      repeat (3 * DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
